@@ hdl/sos_cancel_window_controller_top_defines.svh @@
// Assertion helpers for the alarm controller.
`ifndef SOS_CANCEL_WINDOW_CONTROLLER_TOP_DEFINES_SVH
`define SOS_CANCEL_WINDOW_CONTROLLER_TOP_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define SCWC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scwc check failed: same-cycle rule");

// Next-cycle implication, disabled in reset.
`define SCWC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scwc check failed: next-cycle rule");

`endif

@@ hdl/scwc_pkg.sv @@
package scwc_pkg;

  typedef enum logic [2:0] {
    OP_TRIGGER = 3'd0,
    OP_CANCEL  = 3'd1,
    OP_TICK    = 3'd2,
    OP_ACK     = 3'd3,
    OP_POP     = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    MODE_IDLE       = 2'd0,
    MODE_COUNTDOWN  = 2'd1,
    MODE_DISPATCHED = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    ST_ARMED     = 2'd0,
    ST_CANCELLED = 2'd1,
    ST_CONFIRMED = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    REG_WINDOW   = 2'd0,
    REG_MIN_SENS = 2'd1
  } reg_idx_e;

  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 20;
  localparam int unsigned WindowW    = 20;
  localparam int unsigned MinSensW   = 4;
  localparam int unsigned WinSecW    = 10;
  localparam int unsigned RecipW     = 21;
  localparam int unsigned RecipShift = 30;
  localparam int unsigned QuotW      = 11;

  localparam logic [WindowW-1:0]  WindowReset   = 20'd30000;
  localparam logic [WinSecW-1:0]  WinSecReset   = 10'd30;
  localparam logic [MinSensW-1:0] MinSensReset  = 4'd2;
  localparam logic [RecipW-1:0]   MsToSecRecip  = 21'd1073742;
  localparam logic [WinSecW-1:0]  WinSecMax     = 10'd1023;
  localparam logic [3:0]          ReasonDriver  = 4'd1;
  localparam logic [2:0]          KindCrash     = 3'd0;

  typedef struct packed {
    logic [2:0]         kind;
    logic [7:0]         severity;
    logic [7:0]         sensors;
    logic [31:0]        time_ms;
    status_e            status;
    logic [3:0]         reason;
    logic [WinSecW-1:0] window_sec;
  } rec_t;

  typedef struct packed {
    logic               accepted;
    mode_e              mode;
    logic [WindowW-1:0] remaining;
    logic               popped;
  } step_t;

endpackage

@@ hdl/scwc_if.sv @@
interface scwc_evt_if;
  logic       valid;
  logic       ready;
  logic [2:0] operation;
  logic [2:0] event_kind;
  logic [7:0] sensor_mask;
  logic [7:0] severity;
  logic [31:0] time_now_ms;
  logic [3:0] reason_code;

  modport source (output valid, operation, event_kind, sensor_mask, severity,
                  time_now_ms, reason_code, input ready);
  modport sink   (input valid, operation, event_kind, sensor_mask, severity,
                  time_now_ms, reason_code, output ready);
endinterface

interface scwc_res_if #(parameter int unsigned HELD_W = 4);
  logic              valid;
  logic              ready;
  logic              accepted;
  logic [1:0]        mode_now;
  logic [19:0]       remaining_ms;
  logic              record_valid;
  logic [2:0]        record_kind;
  logic [7:0]        record_severity;
  logic [7:0]        record_sensors;
  logic [31:0]       record_time_ms;
  logic [1:0]        record_status;
  logic [3:0]        record_reason;
  logic [9:0]        record_window_sec;
  logic [HELD_W-1:0] records_held;

  modport source (output valid, accepted, mode_now, remaining_ms, record_valid,
                  record_kind, record_severity, record_sensors, record_time_ms,
                  record_status, record_reason, record_window_sec, records_held,
                  input ready);
  modport sink   (input valid, accepted, mode_now, remaining_ms, record_valid,
                  record_kind, record_severity, record_sensors, record_time_ms,
                  record_status, record_reason, record_window_sec, records_held,
                  output ready);
endinterface

interface scwc_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [19:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ hdl/scwc_ram.sv @@
module scwc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/scwc_ctrl.sv @@
module scwc_ctrl import scwc_pkg::*; #(
  parameter int unsigned RING_DEPTH = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  scwc_evt_if.sink                      evt_i,
  scwc_cfg_if.sink                      cfg_i,
  input  logic                          room_i,
  output step_t                         step_o,
  output logic [$clog2(RING_DEPTH+1)-1:0] held_o,
  output logic                          ram_we_o,
  output logic [$clog2(RING_DEPTH)-1:0] ram_waddr_o,
  output rec_t                          ram_wdata_o,
  output logic                          ram_re_o,
  output logic [$clog2(RING_DEPTH)-1:0] ram_raddr_o
);

  localparam int unsigned AW = $clog2(RING_DEPTH);
  localparam int unsigned CW = $clog2(RING_DEPTH + 1);
  localparam int unsigned SW = AW + 1;
  localparam logic [AW-1:0] LastIdx = AW'(RING_DEPTH - 1);
  localparam logic [CW-1:0] Full    = CW'(RING_DEPTH);
  localparam logic [SW-1:0] DepthS  = SW'(RING_DEPTH);

  logic [WindowW-1:0]  window_q, window_d;
  logic [WinSecW-1:0]  winsec_q, winsec_d;
  logic [MinSensW-1:0] minsens_q, minsens_d;
  mode_e               mode_q, mode_d;
  logic [31:0]         deadline_q, deadline_d;
  rec_t                pend_q, pend_d;
  logic [AW-1:0]       head_q, head_d;
  logic [CW-1:0]       count_q, count_d;

  logic                     fire;
  op_e                      op;
  logic [3:0]               pcount;
  logic                     crash_ok;
  logic                     trig_ok, cancel_ok, tick_ok, pop_ok, push;
  logic [31:0]              late, ahead;
  logic [SW-1:0]            tail_sum;
  logic [AW-1:0]            tail_idx, head_inc;
  logic [WindowW-1:0]       remaining;
  logic [WindowW+RecipW-1:0] win_prod;
  logic [QuotW-1:0]         win_quot;
  rec_t                     wrec;

  assign cfg_i.ready = 1'b1;
  assign evt_i.ready = room_i;
  assign fire        = evt_i.valid && room_i;
  assign op          = op_e'(evt_i.operation);

  always_comb begin
    pcount = '0;
    for (int i = 0; i < 8; i++) begin
      pcount = pcount + 4'(evt_i.sensor_mask[i]);
    end
  end

  assign win_prod = cfg_i.data * MsToSecRecip;
  assign win_quot = win_prod[RecipShift +: QuotW];

  always_comb begin
    window_d  = window_q;
    winsec_d  = winsec_q;
    minsens_d = minsens_q;
    if (cfg_i.valid) begin
      unique case (reg_idx_e'(cfg_i.index))
        REG_WINDOW: begin
          window_d = cfg_i.data;
          winsec_d = (win_quot > QuotW'(WinSecMax)) ? WinSecMax : win_quot[WinSecW-1:0];
        end
        REG_MIN_SENS: minsens_d = cfg_i.data[MinSensW-1:0];
        default: ;
      endcase
    end
  end

  assign crash_ok  = !(evt_i.event_kind == KindCrash && pcount < minsens_q);
  assign late      = evt_i.time_now_ms - deadline_q;
  assign ahead     = deadline_q - evt_i.time_now_ms;
  assign trig_ok   = fire && op == OP_TRIGGER && mode_q == MODE_IDLE && crash_ok;
  assign cancel_ok = fire && op == OP_CANCEL && mode_q == MODE_COUNTDOWN;
  assign tick_ok   = fire && op == OP_TICK && mode_q == MODE_COUNTDOWN && !late[31];
  assign pop_ok    = fire && op == OP_POP && count_q != '0;
  assign push      = trig_ok || cancel_ok || tick_ok;

  always_comb begin
    mode_d = mode_q;
    unique case (mode_q)
      MODE_IDLE: begin
        if (trig_ok) begin
          mode_d = MODE_COUNTDOWN;
        end
      end
      MODE_COUNTDOWN: begin
        if (cancel_ok) begin
          mode_d = MODE_IDLE;
        end else if (tick_ok) begin
          mode_d = MODE_DISPATCHED;
        end
      end
      MODE_DISPATCHED: begin
        if (fire && op == OP_ACK) begin
          mode_d = MODE_IDLE;
        end
      end
      default: mode_d = MODE_IDLE;
    endcase
  end

  assign tail_sum = {1'b0, head_q} + SW'(count_q);
  assign tail_idx = (tail_sum >= DepthS) ? AW'(tail_sum - DepthS) : tail_sum[AW-1:0];
  assign head_inc = (head_q == LastIdx) ? '0 : head_q + 1'b1;

  always_comb begin
    wrec         = pend_q;
    wrec.time_ms = evt_i.time_now_ms;
    wrec.reason  = '0;
    if (trig_ok) begin
      wrec.kind       = evt_i.event_kind;
      wrec.severity   = evt_i.severity;
      wrec.sensors    = evt_i.sensor_mask;
      wrec.status     = ST_ARMED;
      wrec.window_sec = winsec_q;
    end else if (cancel_ok) begin
      wrec.status = ST_CANCELLED;
      wrec.reason = (evt_i.reason_code == '0) ? ReasonDriver : evt_i.reason_code;
    end else begin
      wrec.status = ST_CONFIRMED;
    end
  end

  always_comb begin
    pend_d     = pend_q;
    deadline_d = deadline_q;
    head_d     = head_q;
    count_d    = count_q;
    if (trig_ok) begin
      pend_d     = wrec;
      deadline_d = evt_i.time_now_ms + 32'(window_q);
    end
    if (push) begin
      if (count_q == Full) begin
        head_d = head_inc;
      end else begin
        count_d = count_q + 1'b1;
      end
    end else if (pop_ok) begin
      head_d  = head_inc;
      count_d = count_q - 1'b1;
    end
  end

  always_comb begin
    remaining = '0;
    if (mode_d == MODE_COUNTDOWN) begin
      if (trig_ok) begin
        remaining = window_q;
      end else if (ahead != '0 && !ahead[31]) begin
        remaining = (ahead[30:WindowW] != '0) ? '1 : ahead[WindowW-1:0];
      end
    end
  end

  always_comb begin
    step_o.accepted  = trig_ok || cancel_ok || pop_ok;
    step_o.mode      = mode_d;
    step_o.remaining = remaining;
    step_o.popped    = pop_ok;
    held_o           = count_d;
    ram_we_o         = push;
    ram_waddr_o      = tail_idx;
    ram_wdata_o      = wrec;
    ram_re_o         = pop_ok;
    ram_raddr_o      = head_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q   <= WindowReset;
      winsec_q   <= WinSecReset;
      minsens_q  <= MinSensReset;
      mode_q     <= MODE_IDLE;
      deadline_q <= '0;
      pend_q     <= '0;
      head_q     <= '0;
      count_q    <= '0;
    end else begin
      window_q   <= window_d;
      winsec_q   <= winsec_d;
      minsens_q  <= minsens_d;
      mode_q     <= mode_d;
      deadline_q <= deadline_d;
      pend_q     <= pend_d;
      head_q     <= head_d;
      count_q    <= count_d;
    end
  end

endmodule

@@ hdl/sos_cancel_window_controller_top.sv @@
// Emergency alarm controller: trigger, cancel, tick, acknowledge and pop beats,
// one result beat per input beat. A new input beat is taken every cycle unless
// output back-pressure holds it off; its result passes the stage register, then
// the output register. The record ring sits in one single-port-write RAM with
// a registered read port; all mode and pointer updates finish in the cycle a
// beat is taken, so a following beat waits only on output back-pressure.
// Configuration writes are taken every cycle. There is no clearing pass.
`include "sos_cancel_window_controller_top_defines.svh"

module sos_cancel_window_controller_top import scwc_pkg::*; #(
  parameter int unsigned RING_DEPTH = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  scwc_evt_if.sink   evt_i,
  scwc_cfg_if.sink   cfg_i,
  scwc_res_if.source res_o
);

  localparam int unsigned AW = $clog2(RING_DEPTH);
  localparam int unsigned CW = $clog2(RING_DEPTH + 1);

  step_t          step;
  logic [CW-1:0]  held;
  logic           ram_we, ram_re;
  logic [AW-1:0]  ram_waddr, ram_raddr;
  rec_t           ram_wdata;
  logic [$bits(rec_t)-1:0] ram_rdata;
  rec_t           rd_rec;

  logic           room;
  logic           s1_valid_q, s1_valid_d;
  step_t          s1_step_q;
  logic [CW-1:0]  s1_held_q;
  logic           s1_adv;

  logic           o_valid_q, o_valid_d;
  step_t          o_step_q;
  logic [CW-1:0]  o_held_q;
  rec_t           o_rec_q;

  scwc_ctrl #(.RING_DEPTH(RING_DEPTH)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .evt_i       (evt_i),
    .cfg_i       (cfg_i),
    .room_i      (room),
    .step_o      (step),
    .held_o      (held),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr)
  );

  scwc_ram #(.WIDTH($bits(rec_t)), .DEPTH(RING_DEPTH)) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_rec = rec_t'(ram_rdata);
  assign s1_adv = s1_valid_q && (!o_valid_q || res_o.ready);
  assign room   = !s1_valid_q || s1_adv;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (evt_i.valid && room) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    o_valid_d = o_valid_q;
    if (s1_adv) begin
      o_valid_d = 1'b1;
    end else if (res_o.ready) begin
      o_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      o_valid_q  <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      o_valid_q  <= o_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (evt_i.valid && room) begin
      s1_step_q <= step;
      s1_held_q <= held;
    end
    if (s1_adv) begin
      o_step_q <= s1_step_q;
      o_held_q <= s1_held_q;
      o_rec_q  <= s1_step_q.popped ? rd_rec : '0;
    end
  end

  assign res_o.valid             = o_valid_q;
  assign res_o.accepted          = o_step_q.accepted;
  assign res_o.mode_now          = o_step_q.mode;
  assign res_o.remaining_ms      = o_step_q.remaining;
  assign res_o.record_valid      = o_step_q.popped;
  assign res_o.record_kind       = o_rec_q.kind;
  assign res_o.record_severity   = o_rec_q.severity;
  assign res_o.record_sensors    = o_rec_q.sensors;
  assign res_o.record_time_ms    = o_rec_q.time_ms;
  assign res_o.record_status     = o_rec_q.status;
  assign res_o.record_reason     = o_rec_q.reason;
  assign res_o.record_window_sec = o_rec_q.window_sec;
  assign res_o.records_held      = o_held_q;

  `SCWC_ASSERT_NOW(a_held_bound, clk_i, rst_ni, o_valid_q, o_held_q <= CW'(RING_DEPTH))
  `SCWC_ASSERT_NOW(a_pop_accepted, clk_i, rst_ni, o_valid_q && o_step_q.popped,
                   o_step_q.accepted)
  `SCWC_ASSERT_NOW(a_rem_countdown, clk_i, rst_ni,
                   o_valid_q && o_step_q.remaining != '0, o_step_q.mode == MODE_COUNTDOWN)
  `SCWC_ASSERT_NEXT(a_s1_drains, clk_i, rst_ni, s1_valid_q && !s1_adv,
                    s1_valid_q && $stable(s1_step_q))

endmodule
